[sv/agcg_pkg.sv]
package agcg_pkg;

   // Grid size clamp and corner convention
   localparam int MAX_DIM     = 4096;
   localparam bit PIN_CORNERS = 1'b0;

   // Field widths
   localparam int COEF_W  = 16;
   localparam int DIM_W   = 13;
   localparam int POS_W   = 12;
   localparam int OUT_W   = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Beat layouts
   localparam int REQ_DATA_W = 2 * POS_W;
   localparam int RSP_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

   // Datapath widths
   localparam int NUM_W       = DIM_W + 1;
   localparam int PROD_W      = COEF_W + NUM_W;
   localparam int MAG_W       = PROD_W - 1;
   localparam int RECIP_SHIFT = MAG_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int QUOT_W      = MAG_W + 1;
   localparam int QSUM_W      = QUOT_W + 1;
   localparam int FRAC_W      = 2 * DIM_W;
   localparam int TEST_W      = FRAC_W + 3;
   localparam int SUM_W       = QSUM_W + 1;
   localparam int CNT_W       = $clog2(RECIP_W);

   // Pipeline depth; stages 2 to 7 sit in the term divider
   localparam int STAGE_CNT   = 10;
   localparam int TERM_STAGES = 6;

   localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
   localparam int OUT_MIN = -(1 << (OUT_W - 1));

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COEF_XX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_XY     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_XT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_YX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_YY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_YT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 3'd7;

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic        [DIM_W-1:0]   dim_type;
   typedef logic        [POS_W-1:0]   pos_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef logic        [RECIP_W-1:0] recip_type;
   typedef logic signed [QUOT_W-1:0]  quot_type;
   typedef logic        [TERM_STAGES-1:0] stage_en_type;

   // Clamp a grid size to MAX_DIM
   function automatic dim_type clamp_dim(dim_type n);
      dim_type ne;
      ne = n;
      if (32'(n) > MAX_DIM) begin
         ne = DIM_W'(MAX_DIM);
      end
      return ne;
   endfunction

   // Denominator of the normalized coordinate on one axis
   function automatic dim_type axis_den(dim_type n);
      dim_type ne;
      dim_type d;
      ne = clamp_dim(n);
      if (ne <= DIM_W'(1)) begin
         d = DIM_W'(1);
      end else if (PIN_CORNERS) begin
         d = ne - DIM_W'(1);
      end else begin
         d = ne;
      end
      return d;
   endfunction

   // Numerator 2p + 1 - n, which serves both corner conventions
   function automatic num_type axis_num(pos_type p, dim_type n);
      dim_type ne;
      num_type twice_p;
      num_type size;
      num_type r;
      ne      = clamp_dim(n);
      twice_p = signed'({1'b0, p, 1'b0});
      size    = signed'({1'b0, ne});
      if (ne <= DIM_W'(1)) begin
         r = '0;
      end else begin
         r = twice_p + NUM_W'(1) - size;
      end
      return r;
   endfunction

endpackage

[sv/affine_grid_coordinate_generator_top.sv]
// 2-D affine grid coordinate generator.
// req channel: one beat per pixel, tdata carries col and row. rsp channel:
// one beat per pixel, tdata carries the warped Q6.12 pair grid_x, grid_y,
// saturated. csr channel: writes the six Q4.12 matrix terms and the grid
// size; csr_ready is always high. The user must make writes while no pixel
// is in flight; the block itself does not enforce it.
// Throughput is one pixel per cycle while rsp_tready is high and no reciprocal
// is being rebuilt. The datapath is a ten-stage pipeline (normalize, product,
// magnitude, reciprocal multiply, remainder, correct, sign, cross products,
// rounding test, add and saturate).
// Each per-term quotient uses a reciprocal of the grid denominator. A serial
// divider rebuilds both reciprocals after reset and after every write to
// grid_width or grid_height; req_tready stays low meanwhile.
// When rsp stalls, valid stages hold and empty stages keep filling, so the
// block keeps taking pixels until every stage is occupied. Nothing is lost
// or repeated across a stall.
module affine_grid_coordinate_generator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [agcg_pkg::REQ_DATA_W-1:0]      req_tdata,  // col [11:0], row [23:12]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [agcg_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // grid_x [17:0], grid_y [35:18], zero
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [agcg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [agcg_pkg::CSR_DATA_W-1:0]      csr_data
);
   import agcg_pkg::*;

   // Configuration
   coef_type coef_xx_ff, coef_xy_ff, coef_xt_ff, coef_yx_ff, coef_yy_ff, coef_yt_ff;
   dim_type  grid_width_ff, grid_height_ff;
   logic     csr_fire;
   logic     grid_write;

   // Derived denominators
   dim_type  den_x_c, den_y_c;
   dim_type  dx_ff, dy_ff;
   logic [FRAC_W-1:0] dxy_ff;

   // Reciprocal divider
   logic              recip_busy_ff, recip_busy_in;
   logic [CNT_W-1:0]  recip_cnt_ff, recip_cnt_in;
   dim_type           rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   recip_type         recip_x_ff, recip_x_in, recip_y_ff, recip_y_in;
   logic              dvd_bit;
   logic [DIM_W:0]    shift_x, shift_y;

   // Pipeline control
   logic [STAGE_CNT:1] valid_ff;
   logic [STAGE_CNT:1] stage_en;
   logic               req_fire;

   // Stage payloads
   num_type  nx_ff, ny_ff;
   quot_type q_xa, q_xb, q_ya, q_yb;
   dim_type  r_xa, r_xb, r_ya, r_yb;
   logic signed [QSUM_W-1:0] qsum_x_ff, qsum_y_ff, qsum_x2_ff, qsum_y2_ff;
   logic [FRAC_W-1:0] fxa_ff, fxb_ff, fya_ff, fyb_ff;
   logic [1:0]        kx_ff, kx_in, ky_ff, ky_in;
   logic [TEST_W-1:0] tx, ty, two_d, four_d;
   logic signed [SUM_W-1:0] vx, vy;
   logic signed [OUT_W-1:0] grid_x_ff, grid_x_in, grid_y_ff, grid_y_in;

   // Register writes
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign grid_write = csr_fire &&
                       (csr_index == REG_GRID_WIDTH || csr_index == REG_GRID_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff     <= COEF_W'(4096);
         coef_xy_ff     <= '0;
         coef_xt_ff     <= '0;
         coef_yx_ff     <= '0;
         coef_yy_ff     <= COEF_W'(4096);
         coef_yt_ff     <= '0;
         grid_width_ff  <= DIM_W'(1);
         grid_height_ff <= DIM_W'(1);
      end else if (csr_fire) begin
         unique case (csr_index)
            REG_COEF_XX:     coef_xx_ff     <= csr_data;
            REG_COEF_XY:     coef_xy_ff     <= csr_data;
            REG_COEF_XT:     coef_xt_ff     <= csr_data;
            REG_COEF_YX:     coef_yx_ff     <= csr_data;
            REG_COEF_YY:     coef_yy_ff     <= csr_data;
            REG_COEF_YT:     coef_yt_ff     <= csr_data;
            REG_GRID_WIDTH:  grid_width_ff  <= csr_data[DIM_W-1:0];
            REG_GRID_HEIGHT: grid_height_ff <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Track denominators and their product
   assign den_x_c = axis_den(grid_width_ff);
   assign den_y_c = axis_den(grid_height_ff);

   always_ff @(posedge clock) begin
      dx_ff  <= den_x_c;
      dy_ff  <= den_y_c;
      dxy_ff <= FRAC_W'(den_x_c) * FRAC_W'(den_y_c);
   end

   // Restoring division of 2^RECIP_SHIFT by each denominator, one bit a cycle
   always_comb begin
      dvd_bit       = (recip_cnt_ff == '0);
      shift_x       = {rem_x_ff, dvd_bit};
      shift_y       = {rem_y_ff, dvd_bit};
      recip_busy_in = recip_busy_ff;
      recip_cnt_in  = recip_cnt_ff;
      rem_x_in      = rem_x_ff;
      rem_y_in      = rem_y_ff;
      recip_x_in    = recip_x_ff;
      recip_y_in    = recip_y_ff;
      if (grid_write) begin
         recip_busy_in = 1'b1;
         recip_cnt_in  = '0;
         rem_x_in      = '0;
         rem_y_in      = '0;
      end else if (recip_busy_ff) begin
         if (shift_x >= {1'b0, den_x_c}) begin
            rem_x_in   = DIM_W'(shift_x - {1'b0, den_x_c});
            recip_x_in = {recip_x_ff[RECIP_W-2:0], 1'b1};
         end else begin
            rem_x_in   = shift_x[DIM_W-1:0];
            recip_x_in = {recip_x_ff[RECIP_W-2:0], 1'b0};
         end
         if (shift_y >= {1'b0, den_y_c}) begin
            rem_y_in   = DIM_W'(shift_y - {1'b0, den_y_c});
            recip_y_in = {recip_y_ff[RECIP_W-2:0], 1'b1};
         end else begin
            rem_y_in   = shift_y[DIM_W-1:0];
            recip_y_in = {recip_y_ff[RECIP_W-2:0], 1'b0};
         end
         recip_cnt_in = recip_cnt_ff + CNT_W'(1);
         if (recip_cnt_ff == CNT_W'(RECIP_W - 1)) begin
            recip_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_busy_ff <= 1'b1;
         recip_cnt_ff  <= '0;
         rem_x_ff      <= '0;
         rem_y_ff      <= '0;
      end else begin
         recip_busy_ff <= recip_busy_in;
         recip_cnt_ff  <= recip_cnt_in;
         rem_x_ff      <= rem_x_in;
         rem_y_ff      <= rem_y_in;
      end
      recip_x_ff <= recip_x_in;
      recip_y_ff <= recip_y_in;
   end

   // A stage advances when it is empty or the stage after it advances
   always_comb begin
      stage_en[STAGE_CNT] = !valid_ff[STAGE_CNT] || rsp_tready;
      for (int i = STAGE_CNT - 1; i >= 1; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign req_tready = stage_en[1] && !recip_busy_ff;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            valid_ff[1] <= req_fire;
         end
         for (int i = 2; i <= STAGE_CNT; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Stage 1: normalized numerators
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         nx_ff <= axis_num(req_tdata[POS_W-1:0], grid_width_ff);
         ny_ff <= axis_num(req_tdata[2*POS_W-1:POS_W], grid_height_ff);
      end
   end

   // Stages 2 to 7: four floor quotients with remainders
   agcg_term u_term_xa (
      .clock (clock), .en (stage_en[7:2]), .coef (coef_xx_ff), .num (nx_ff),
      .den (dx_ff), .recip (recip_x_ff), .quot (q_xa), .rem (r_xa)
   );
   agcg_term u_term_xb (
      .clock (clock), .en (stage_en[7:2]), .coef (coef_xy_ff), .num (ny_ff),
      .den (dy_ff), .recip (recip_y_ff), .quot (q_xb), .rem (r_xb)
   );
   agcg_term u_term_ya (
      .clock (clock), .en (stage_en[7:2]), .coef (coef_yx_ff), .num (nx_ff),
      .den (dx_ff), .recip (recip_x_ff), .quot (q_ya), .rem (r_ya)
   );
   agcg_term u_term_yb (
      .clock (clock), .en (stage_en[7:2]), .coef (coef_yy_ff), .num (ny_ff),
      .den (dy_ff), .recip (recip_y_ff), .quot (q_yb), .rem (r_yb)
   );

   // Stage 8: bring remainders over the common denominator, add quotients
   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         fxa_ff    <= FRAC_W'(r_xa) * FRAC_W'(dy_ff);
         fxb_ff    <= FRAC_W'(r_xb) * FRAC_W'(dx_ff);
         fya_ff    <= FRAC_W'(r_ya) * FRAC_W'(dy_ff);
         fyb_ff    <= FRAC_W'(r_yb) * FRAC_W'(dx_ff);
         qsum_x_ff <= QSUM_W'(q_xa) + QSUM_W'(q_xb);
         qsum_y_ff <= QSUM_W'(q_ya) + QSUM_W'(q_yb);
      end
   end

   // Stage 9: round half up; the fraction plus one half lands in 0, 1 or 2
   always_comb begin
      two_d  = TEST_W'(dxy_ff) << 1;
      four_d = TEST_W'(dxy_ff) << 2;
      tx = ((TEST_W'(fxa_ff) + TEST_W'(fxb_ff)) << 1) + TEST_W'(dxy_ff);
      ty = ((TEST_W'(fya_ff) + TEST_W'(fyb_ff)) << 1) + TEST_W'(dxy_ff);
      kx_in = (tx >= four_d) ? 2'd2 : (tx >= two_d) ? 2'd1 : 2'd0;
      ky_in = (ty >= four_d) ? 2'd2 : (ty >= two_d) ? 2'd1 : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         kx_ff      <= kx_in;
         ky_ff      <= ky_in;
         qsum_x2_ff <= qsum_x_ff;
         qsum_y2_ff <= qsum_y_ff;
      end
   end

   // Stage 10: add translation and saturate
   always_comb begin
      vx = SUM_W'(qsum_x2_ff) + signed'(SUM_W'(kx_ff)) + SUM_W'(coef_xt_ff);
      vy = SUM_W'(qsum_y2_ff) + signed'(SUM_W'(ky_ff)) + SUM_W'(coef_yt_ff);
      if (vx > SUM_W'(OUT_MAX)) begin
         grid_x_in = OUT_W'(OUT_MAX);
      end else if (vx < SUM_W'(OUT_MIN)) begin
         grid_x_in = OUT_W'(OUT_MIN);
      end else begin
         grid_x_in = vx[OUT_W-1:0];
      end
      if (vy > SUM_W'(OUT_MAX)) begin
         grid_y_in = OUT_W'(OUT_MAX);
      end else if (vy < SUM_W'(OUT_MIN)) begin
         grid_y_in = OUT_W'(OUT_MIN);
      end else begin
         grid_y_in = vy[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         grid_x_ff <= grid_x_in;
         grid_y_ff <= grid_y_in;
      end
   end

   assign rsp_tvalid = valid_ff[STAGE_CNT];
   assign rsp_tdata  = {(RSP_DATA_W - 2*OUT_W)'(0), grid_y_ff, grid_x_ff};

   // No pixel enters while a reciprocal is being rebuilt
   assert property (@(posedge clock) disable iff (reset)
      recip_busy_ff |-> !req_tready)
      else $error("pixel accepted during reciprocal rebuild");

   // An item leaving the rounding stage reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGE_CNT-1] && stage_en[STAGE_CNT]) |=> rsp_tvalid)
      else $error("item lost before the output register");

   // Finished reciprocals are the floor of 2^RECIP_SHIFT over each denominator
   assert property (@(posedge clock) disable iff (reset)
      $fell(recip_busy_ff) |->
         (64'(recip_x_ff) * 64'(dx_ff) <= (64'(1) << RECIP_SHIFT)) &&
         ((64'(recip_x_ff) + 64'(1)) * 64'(dx_ff) > (64'(1) << RECIP_SHIFT)) &&
         (64'(recip_y_ff) * 64'(dy_ff) <= (64'(1) << RECIP_SHIFT)) &&
         ((64'(recip_y_ff) + 64'(1)) * 64'(dy_ff) > (64'(1) << RECIP_SHIFT)))
      else $error("reciprocal out of range");

   // A stalled output holds every stage behind a full pipeline
   assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_tready) |-> !req_tready)
      else $error("pixel accepted into a full, stalled pipeline");

endmodule

[sv/agcg_term.sv]
// Floor division of coef * num by a grid denominator, using a precomputed
// reciprocal and one correction step. Six register stages.
module agcg_term (
   input  logic                  clock,
   input  agcg_pkg::stage_en_type en,
   input  agcg_pkg::coef_type    coef,
   input  agcg_pkg::num_type     num,
   input  agcg_pkg::dim_type     den,
   input  agcg_pkg::recip_type   recip,
   output agcg_pkg::quot_type    quot,
   output agcg_pkg::dim_type     rem
);
   import agcg_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         mag2_ff;
   logic [MAG_W-1:0]         q0_ff, q0_in;
   logic                     neg2_ff;
   logic [MAG_W-1:0]         q0b_ff;
   logic [DIM_W:0]           r0_ff, r0_in;
   logic                     neg3_ff;
   logic [MAG_W-1:0]         q1_ff, q1_in;
   dim_type                  r1_ff, r1_in;
   logic                     neg4_ff;
   quot_type                 qs_ff, qs_in;
   dim_type                  rs_ff, rs_in;

   logic [MAG_W+RECIP_W-1:0] wide;
   logic [MAG_W+DIM_W-1:0]   back;
   quot_type                 qpos;

   // Signed product, then magnitude and sign
   always_comb begin
      prod_in = PROD_W'(coef) * PROD_W'(num);
      neg_in  = prod_ff[PROD_W-1];
      mag_in  = neg_in ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
   end

   // Estimate quotient by reciprocal, then take the remainder
   always_comb begin
      wide  = (MAG_W+RECIP_W)'(mag_ff) * (MAG_W+RECIP_W)'(recip);
      q0_in = MAG_W'(wide >> RECIP_SHIFT);
      back  = (MAG_W+DIM_W)'(q0_ff) * (MAG_W+DIM_W)'(den);
      r0_in = (DIM_W+1)'(mag2_ff - MAG_W'(back));
   end

   // Estimate is at most one short: correct it, then restore the sign with floor
   always_comb begin
      if (r0_ff >= {1'b0, den}) begin
         q1_in = q0b_ff + MAG_W'(1);
         r1_in = DIM_W'(r0_ff - {1'b0, den});
      end else begin
         q1_in = q0b_ff;
         r1_in = DIM_W'(r0_ff);
      end
      qpos = signed'({1'b0, q1_ff});
      if (neg4_ff) begin
         qs_in = -qpos - quot_type'(r1_ff != '0);
         rs_in = (r1_ff != '0) ? den - r1_ff : '0;
      end else begin
         qs_in = qpos;
         rs_in = r1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
      end
      if (en[1]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (en[2]) begin
         q0_ff   <= q0_in;
         mag2_ff <= mag_ff;
         neg2_ff <= neg_ff;
      end
      if (en[3]) begin
         r0_ff   <= r0_in;
         q0b_ff  <= q0_ff;
         neg3_ff <= neg2_ff;
      end
      if (en[4]) begin
         q1_ff   <= q1_in;
         r1_ff   <= r1_in;
         neg4_ff <= neg3_ff;
      end
      if (en[5]) begin
         qs_ff <= qs_in;
         rs_ff <= rs_in;
      end
   end

   assign quot = qs_ff;
   assign rem  = rs_ff;

endmodule
